@@ sv/cwre_pkg.sv @@
package cwre_pkg;

    // field widths
    localparam int ACTION_W = 2;
    localparam int RTT_W    = 16;
    localparam int WIN_W    = 20;
    localparam int RTO_W    = 13;
    localparam int CNT_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SRTT_W   = 22;
    localparam int DEV_W    = 20;

    // window fixed point
    localparam int WINDOW_FRAC_BITS = 4;
    localparam logic [WIN_W-1:0] ONE_WINDOW = WIN_W'(1 << WINDOW_FRAC_BITS);
    localparam logic [WIN_W-1:0] TWO_WINDOW = WIN_W'(2 << WINDOW_FRAC_BITS);

    // outstanding count limit
    localparam logic [CNT_W-1:0] MAX_OUTSTANDING = CNT_W'(1024);

    // retransmit timeout limits in ms
    localparam logic [RTO_W-1:0] RTO_MAX   = RTO_W'(5000);
    localparam logic [RTO_W-1:0] RTO_MIN   = RTO_W'(500);
    localparam logic [RTO_W-1:0] RTO_GUARD = RTO_W'(10);

    // register reset values
    localparam logic [WIN_W-1:0] INITIAL_CWND_RST   = WIN_W'(32);
    localparam logic [WIN_W-1:0] WINDOW_CEILING_RST = WIN_W'(1024);

    // event kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_SEND    = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CWND   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CEILING = CFG_IDX_W'(1);

endpackage

@@ sv/congestion_window_rto_estimator_core.sv @@
// Sender congestion window and retransmit timeout tracker. Each input word is one event
// (send, ack or timeout) and produces exactly one result word holding the state after the
// update. Events pass the input, then the result register; one event is taken every cycle
// unless the result stalls, set by the single registered update of the estimator and window
// state, and a stalled result holds back the input side only once both the input and result
// registers are full. Configuration writes load the registers at once and also reload cwnd
// (initial window) or ssthresh and the receiver window (ceiling); write them only while idle.
module congestion_window_rto_estimator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [cwre_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cwre_pkg::WIN_W-1:0]        i_cfg_data,
    // event input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cwre_pkg::ACTION_W-1:0]     i_action,
    input  logic                              i_ack_matched,
    input  logic [cwre_pkg::RTT_W-1:0]        i_rtt_sample_ms,
    input  logic [cwre_pkg::WIN_W-1:0]        i_peer_window,
    input  logic                              i_timeout_counts,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cwre_pkg::RTO_W-1:0]        o_rto_ms,
    output logic [cwre_pkg::WIN_W-1:0]        o_cwnd_out,
    output logic [cwre_pkg::WIN_W-1:0]        o_ssthresh_out,
    output logic [cwre_pkg::WIN_W-1:0]        o_rwnd_out,
    output logic [cwre_pkg::CNT_W-1:0]        o_in_flight,
    output logic                              o_window_open
);

    localparam int WIN_W  = cwre_pkg::WIN_W;
    localparam int RTT_W  = cwre_pkg::RTT_W;
    localparam int RTO_W  = cwre_pkg::RTO_W;
    localparam int CNT_W  = cwre_pkg::CNT_W;
    localparam int SRTT_W = cwre_pkg::SRTT_W;
    localparam int DEV_W  = cwre_pkg::DEV_W;
    localparam int MEAN_W = SRTT_W - 3;
    localparam int SUM_W  = 21;

    // clamp a wide timeout into the legal range
    function automatic logic [RTO_W-1:0] clamp_rto(input logic [SUM_W-1:0] v);
        logic [RTO_W-1:0] res;
        if (v > SUM_W'(cwre_pkg::RTO_MAX)) begin
            res = cwre_pkg::RTO_MAX;
        end else if (v < SUM_W'(cwre_pkg::RTO_MIN)) begin
            res = cwre_pkg::RTO_MIN;
        end else begin
            res = v[RTO_W-1:0];
        end
        return res;
    endfunction

    // input register
    logic                      r_in_valid;
    logic [cwre_pkg::ACTION_W-1:0] r_action;
    logic                      r_matched;
    logic [RTT_W-1:0]          r_rtt;
    logic [WIN_W-1:0]          r_peer;
    logic                      r_counts;

    // configuration registers
    logic [WIN_W-1:0]          r_ceiling;

    // estimator and window state
    logic                      r_have_sample, n_have_sample;
    logic [SRTT_W-1:0]         r_srtt, n_srtt;
    logic [DEV_W-1:0]          r_dev, n_dev;
    logic [RTO_W-1:0]          r_rto, n_rto;
    logic [WIN_W-1:0]          r_cwnd, n_cwnd;
    logic [WIN_W-1:0]          r_ssthresh, n_ssthresh;
    logic [WIN_W-1:0]          r_rwnd, n_rwnd;
    logic [CNT_W-1:0]          r_outstanding, n_outstanding;
    logic                      n_window_open;

    // result register
    logic                      r_out_valid;
    logic [RTO_W-1:0]          r_rto_ms;
    logic [WIN_W-1:0]          r_cwnd_out;
    logic [WIN_W-1:0]          r_ssthresh_out;
    logic [WIN_W-1:0]          r_rwnd_out;
    logic [CNT_W-1:0]          r_in_flight;
    logic                      r_window_open;

    // handshake
    logic advance;
    logic in_ready;

    assign advance    = !r_out_valid || !i_out_stall;
    assign in_ready   = !r_in_valid || advance;
    assign o_in_stall = !in_ready;

    // estimator datapath
    logic [MEAN_W-1:0]  mean;
    logic [MEAN_W-1:0]  sample;
    logic [MEAN_W-1:0]  mag;
    logic [SRTT_W-1:0]  est_srtt;
    logic [DEV_W-1:0]   est_dev;
    logic [SUM_W-1:0]   est_rto_raw;
    logic [SUM_W-1:0]   first_rto_raw;
    logic [WIN_W:0]     grow;
    logic [WIN_W-1:0]   grown_cwnd;
    logic [WIN_W-1:0]   half_cwnd;
    logic [WIN_W-1:0]   lim_win;

    always_comb begin
        mean          = r_srtt[SRTT_W-1:3];
        sample        = MEAN_W'(r_rtt);
        mag           = (mean >= sample) ? (mean - sample) : (sample - mean);
        est_srtt      = r_srtt - SRTT_W'(mean) + SRTT_W'(r_rtt);
        est_dev       = DEV_W'((SUM_W'(r_dev) + SUM_W'(mag)) - SUM_W'(r_dev[DEV_W-1:2]));
        est_rto_raw   = SUM_W'(est_srtt[SRTT_W-1:3]) + SUM_W'(est_dev)
                      + SUM_W'(cwre_pkg::RTO_GUARD);
        first_rto_raw = SUM_W'({r_rtt, 2'b00}) + SUM_W'(cwre_pkg::RTO_GUARD);
    end

    // window growth, slow start doubles
    always_comb begin
        if (r_cwnd < r_ssthresh) begin
            grow = {r_cwnd, 1'b0};
        end else begin
            grow = {1'b0, r_cwnd} + (WIN_W+1)'(cwre_pkg::ONE_WINDOW);
        end
        grown_cwnd = (grow > {1'b0, r_ceiling}) ? r_ceiling : grow[WIN_W-1:0];
        half_cwnd  = {1'b0, r_cwnd[WIN_W-1:1]};
    end

    // next state for the event in the input register
    always_comb begin
        n_have_sample = r_have_sample;
        n_srtt        = r_srtt;
        n_dev         = r_dev;
        n_rto         = r_rto;
        n_cwnd        = r_cwnd;
        n_ssthresh    = r_ssthresh;
        n_rwnd        = r_rwnd;
        n_outstanding = r_outstanding;
        case (cwre_pkg::t_action'(r_action))
            cwre_pkg::ACT_SEND: begin
                if (r_outstanding < cwre_pkg::MAX_OUTSTANDING) begin
                    n_outstanding = r_outstanding + CNT_W'(1);
                end
            end
            cwre_pkg::ACT_ACK: begin
                n_rwnd = r_peer;
                if (r_matched) begin
                    if (r_outstanding != '0) begin
                        n_outstanding = r_outstanding - CNT_W'(1);
                    end
                    n_have_sample = 1'b1;
                    if (!r_have_sample) begin
                        n_srtt = SRTT_W'({r_rtt, 3'b000});
                        n_dev  = '0;
                        n_rto  = clamp_rto(first_rto_raw);
                    end else begin
                        n_srtt = est_srtt;
                        n_dev  = est_dev;
                        n_rto  = clamp_rto(est_rto_raw);
                    end
                    n_cwnd = grown_cwnd;
                end
            end
            cwre_pkg::ACT_TIMEOUT: begin
                if (r_counts) begin
                    n_rto      = clamp_rto(SUM_W'({r_rto, 1'b0}));
                    n_ssthresh = (half_cwnd < cwre_pkg::TWO_WINDOW) ?
                                 cwre_pkg::TWO_WINDOW : half_cwnd;
                    n_cwnd     = cwre_pkg::TWO_WINDOW;
                end
                if (r_outstanding != '0) begin
                    n_outstanding = r_outstanding - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        lim_win       = ((n_cwnd < n_rwnd) ? n_cwnd : n_rwnd) >> cwre_pkg::WINDOW_FRAC_BITS;
        n_window_open = (WIN_W'(n_outstanding) < lim_win);
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (in_ready && i_in_valid) begin
            r_action  <= i_action;
            r_matched <= i_ack_matched;
            r_rtt     <= i_rtt_sample_ms;
            r_peer    <= i_peer_window;
            r_counts  <= i_timeout_counts;
        end
    end

    // state update and configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling      <= cwre_pkg::WINDOW_CEILING_RST;
            r_have_sample  <= 1'b0;
            r_srtt         <= '0;
            r_dev          <= '0;
            r_rto          <= cwre_pkg::RTO_MAX;
            r_cwnd         <= cwre_pkg::INITIAL_CWND_RST;
            r_ssthresh     <= cwre_pkg::WINDOW_CEILING_RST;
            r_rwnd         <= cwre_pkg::WINDOW_CEILING_RST;
            r_outstanding  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == cwre_pkg::CFG_INITIAL_CWND) begin
                r_cwnd         <= i_cfg_data;
            end else if (i_cfg_index == cwre_pkg::CFG_WINDOW_CEILING) begin
                r_ceiling  <= i_cfg_data;
                r_ssthresh <= i_cfg_data;
                r_rwnd     <= i_cfg_data;
            end
        end else if (r_in_valid && advance) begin
            r_have_sample <= n_have_sample;
            r_srtt        <= n_srtt;
            r_dev         <= n_dev;
            r_rto         <= n_rto;
            r_cwnd        <= n_cwnd;
            r_ssthresh    <= n_ssthresh;
            r_rwnd        <= n_rwnd;
            r_outstanding <= n_outstanding;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_rto_ms       <= n_rto;
            r_cwnd_out     <= n_cwnd;
            r_ssthresh_out <= n_ssthresh;
            r_rwnd_out     <= n_rwnd;
            r_in_flight    <= n_outstanding;
            r_window_open  <= n_window_open;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rto_ms       = r_rto_ms;
    assign o_cwnd_out     = r_cwnd_out;
    assign o_ssthresh_out = r_ssthresh_out;
    assign o_rwnd_out     = r_rwnd_out;
    assign o_in_flight    = r_in_flight;
    assign o_window_open  = r_window_open;

    // timeout always stays within its clamp range
    a_rto_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rto >= cwre_pkg::RTO_MIN) && (r_rto <= cwre_pkg::RTO_MAX))
        else $error("rto out of range");

    // outstanding count never passes its ceiling
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= cwre_pkg::MAX_OUTSTANDING)
        else $error("outstanding count above limit");

    // a full pipe with a stalled result pushes back on the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipe is full");

    // a held result word keeps its state fields
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_rto_ms)
                                          && $stable(r_in_flight)))
        else $error("stalled result changed");

endmodule
